[sv/ihs_pkg.sv]
// Shared types, constants and state encodings for the integer hash set.
package ihs_pkg;

	// Key and configuration widths
	localparam int KEY_W       = 32;
	localparam int BUCKET_W    = 4;
	localparam int MAX_MODULUS = 15;
	localparam int DIV_STEPS   = 32;
	localparam int CNT_W       = 5;

	// Configuration port decoding
	localparam int APB_DATA_W = 32;
	localparam int ADDR_W     = 3;
	localparam int REG_IDX_W  = 1;
	localparam logic [REG_IDX_W-1:0] REG_BUCKET_COUNT = 1'b0;
	localparam logic [BUCKET_W-1:0]  BUCKET_COUNT_RESET = 4'd8;

	// Request operations
	typedef enum logic {
		OP_INSERT = 1'b0,
		OP_LOOKUP = 1'b1
	} ihs_op_t;

	// Input beat
	typedef struct packed {
		logic              op;
		logic signed [31:0] key;
	} ihs_req_t;

	// Output beat
	typedef struct packed {
		logic       present;
		logic       added;
		logic       bucket_full;
		logic [2:0] bucket_index;
	} ihs_resp_t;

	// Request handed to the bucket search unit
	typedef struct packed {
		logic                op;
		logic [KEY_W-1:0]    key;
		logic [BUCKET_W-1:0] bucket;
	} ihs_search_req_t;

	// Status returned by the bucket search unit
	typedef struct packed {
		logic done;
		logic present;
		logic added;
		logic full;
	} ihs_search_stat_t;

	// Top-level sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_HASH,
		ST_SEARCH,
		ST_OUTPUT
	} ihs_top_state_t;

	// Bucket search states
	typedef enum logic [1:0] {
		SR_IDLE,
		SR_READ,
		SR_COMPARE,
		SR_COMMIT
	} ihs_search_state_t;

endpackage

[sv/ihs_mod_unit.sv]
// Bit-serial remainder unit: a 32-bit magnitude modulo a small divisor.
module ihs_mod_unit import ihs_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [KEY_W-1:0]    dividend,
	input  logic [BUCKET_W-1:0] divisor,
	output logic                done,
	output logic [BUCKET_W-1:0] remainder
);

	logic                busy_q;
	logic                done_q;
	logic [CNT_W-1:0]    count_q;
	logic [KEY_W-1:0]    dvd_q;
	logic [BUCKET_W-1:0] div_q;
	logic [BUCKET_W-1:0] rem_q;

	logic [BUCKET_W:0]   trial;
	logic                trial_ge;
	logic [BUCKET_W-1:0] rem_next;

	// One restoring step: bring in the next dividend bit, subtract if it fits.
	always_comb begin
		trial    = {rem_q, dvd_q[KEY_W-1]};
		trial_ge = (trial >= {1'b0, div_q});
		rem_next = trial_ge ? BUCKET_W'(trial - {1'b0, div_q}) : trial[BUCKET_W-1:0];
	end

	// Step control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			count_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q  <= 1'b1;
				count_q <= CNT_W'(DIV_STEPS - 1);
			end else if (busy_q) begin
				count_q <= count_q - CNT_W'(1);
				if (count_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Operand and partial remainder registers
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			div_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[KEY_W-2:0], 1'b0};
			rem_q <= rem_next;
		end
	end

	assign done      = done_q;
	assign remainder = rem_q;

	// The result is always reduced below the divisor.
	a_rem_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> rem_q < div_q)
		else $error("remainder not reduced below divisor");

	// A started division keeps running until its last step.
	a_busy_runs: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && count_q != '0 && !start |=> busy_q)
		else $error("division stopped early");

	// Completion follows only a running division.
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q))
		else $error("done without a running division");

endmodule

[sv/ihs_bucket_search.sv]
// Bucket slot store with fill counts and a sequencer that scans and inserts.
module ihs_bucket_search import ihs_pkg::*; #(
	parameter int BUCKETS          = 8,
	parameter int SLOTS_PER_BUCKET = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  ihs_search_req_t  req,
	output ihs_search_stat_t stat
);

	// Only buckets below the largest programmable modulus are reachable.
	localparam int USED_BUCKETS = (BUCKETS < MAX_MODULUS) ? BUCKETS : MAX_MODULUS;
	localparam int UB_W      = (USED_BUCKETS > 1) ? $clog2(USED_BUCKETS) : 1;
	localparam int SW        = (SLOTS_PER_BUCKET > 1) ? $clog2(SLOTS_PER_BUCKET) : 1;
	localparam int FW        = $clog2(SLOTS_PER_BUCKET + 1);
	localparam int MEM_DEPTH = USED_BUCKETS * (2 ** SW);
	localparam int AW        = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
	localparam logic [FW-1:0] SLOTS_FILL = FW'(SLOTS_PER_BUCKET);

	ihs_search_state_t state_q, state_d;

	logic [KEY_W-1:0] mem [MEM_DEPTH];
	logic [KEY_W-1:0] rdata_q;
	logic [FW-1:0]    fill_q [USED_BUCKETS];

	logic [KEY_W-1:0] key_q;
	logic             op_q;
	logic [UB_W-1:0]  bucket_q;
	logic [FW-1:0]    fill_cur_q;
	logic [FW-1:0]    slot_q;
	logic             present_q;
	logic             added_q;
	logic             full_q;
	logic             done_q;

	logic [UB_W-1:0]  req_bucket;
	logic             match;
	logic             last_slot;
	logic             mem_re;
	logic             mem_we;
	logic [AW-1:0]    raddr;
	logic [AW-1:0]    waddr;

	assign req_bucket = req.bucket[UB_W-1:0];
	assign match      = (rdata_q == key_q);
	assign last_slot  = ((slot_q + FW'(1)) == fill_cur_q);
	assign raddr      = AW'({bucket_q, slot_q[SW-1:0]});
	assign waddr      = AW'({bucket_q, fill_cur_q[SW-1:0]});

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			SR_IDLE: begin
				if (start) begin
					state_d = (fill_q[req_bucket] == '0) ? SR_COMMIT : SR_READ;
				end
			end
			SR_READ: begin
				state_d = SR_COMPARE;
			end
			SR_COMPARE: begin
				if (match || last_slot) begin
					state_d = SR_COMMIT;
				end else begin
					state_d = SR_READ;
				end
			end
			SR_COMMIT: begin
				state_d = SR_IDLE;
			end
			default: begin
				state_d = SR_IDLE;
			end
		endcase
	end

	// Memory strobes
	always_comb begin
		mem_re = (state_q == SR_READ);
		mem_we = (state_q == SR_COMMIT) && (op_q == OP_INSERT) && !present_q &&
			(fill_cur_q < SLOTS_FILL);
	end

	// Sequencer and control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= SR_IDLE;
			op_q       <= 1'b0;
			bucket_q   <= '0;
			fill_cur_q <= '0;
			slot_q     <= '0;
			present_q  <= 1'b0;
			added_q    <= 1'b0;
			full_q     <= 1'b0;
			done_q     <= 1'b0;
			for (int i = 0; i < USED_BUCKETS; i++) begin
				fill_q[i] <= '0;
			end
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == SR_COMMIT);
			unique case (state_q)
				SR_IDLE: begin
					if (start) begin
						op_q       <= req.op;
						bucket_q   <= req_bucket;
						fill_cur_q <= fill_q[req_bucket];
						slot_q     <= '0;
						present_q  <= 1'b0;
						added_q    <= 1'b0;
						full_q     <= 1'b0;
					end
				end
				SR_READ: begin
				end
				SR_COMPARE: begin
					if (match) begin
						present_q <= 1'b1;
					end
					slot_q <= slot_q + FW'(1);
				end
				SR_COMMIT: begin
					if (mem_we) begin
						fill_q[bucket_q] <= fill_cur_q + FW'(1);
						added_q          <= 1'b1;
					end else if (op_q == OP_INSERT && !present_q) begin
						full_q <= 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Key register
	always_ff @(posedge clk) begin
		if (state_q == SR_IDLE && start) begin
			key_q <= req.key;
		end
	end

	// Slot memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[waddr] <= key_q;
		end
		if (mem_re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign stat = '{done: done_q, present: present_q, added: added_q, full: full_q};

	// The scan never reads beyond the slots in use.
	a_scan_in_fill: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == SR_COMPARE |-> slot_q < fill_cur_q)
		else $error("slot scan beyond fill count");

	// Completion is reported only after a commit.
	a_done_after_commit: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(state_q == SR_COMMIT))
		else $error("search done without commit");

	// A stored key was neither found nor refused.
	a_added_clean: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && added_q |-> !present_q && !full_q && op_q == OP_INSERT)
		else $error("inconsistent insert outcome");

endmodule

[sv/integer_hash_set.sv]
// Top level of the integer hash set: request sequencer, configuration and result register.
// A set of signed 32-bit keys held in BUCKETS buckets of SLOTS_PER_BUCKET slots each. A key
// goes to bucket |key| mod bucket_count (0 reads as 1, values above min(BUCKETS, 15) as that cap;
// the most negative key has magnitude 2^31). A request passes the bit-serial remainder unit,
// which brings in one key bit per cycle, then a read and a compare per occupied slot in the slot
// memory until a match or the last slot, a commit step and the hand-over of the outcome to the
// output register. One
// request is in progress at a time; in_stall stays high until its result has been loaded into
// the output register, and the next request may be accepted while that result waits. The store
// is empty after reset with no clearing pass. Change bucket_count only while idle.
module integer_hash_set import ihs_pkg::*; #(
	parameter int BUCKETS          = 8,
	parameter int SLOTS_PER_BUCKET = 4
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  ihs_req_t              in_data,
	output logic                  out_valid,
	input  logic                  out_stall,
	output ihs_resp_t             out_data,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [ADDR_W-1:0]     paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready
);

	localparam int USED_BUCKETS = (BUCKETS < MAX_MODULUS) ? BUCKETS : MAX_MODULUS;
	localparam logic [BUCKET_W-1:0] MOD_CAP = BUCKET_W'(USED_BUCKETS);

	ihs_top_state_t   state_q, state_d;
	logic [BUCKET_W-1:0] bucket_count_q;
	logic                op_q;
	logic [KEY_W-1:0]    key_q;
	logic [BUCKET_W-1:0] bucket_q;
	logic                out_valid_q;
	ihs_resp_t           out_data_q;

	logic                reg_sel;
	logic                cfg_write;
	logic [BUCKET_W-1:0] modulus;
	logic [KEY_W-1:0]    key_bits;
	logic [KEY_W-1:0]    magnitude;
	logic                div_start;
	logic                div_done;
	logic [BUCKET_W-1:0] div_rem;
	logic                search_start;
	ihs_search_req_t     search_req;
	ihs_search_stat_t    search_stat;
	logic                out_load;

	// Configuration port
	assign reg_sel   = (paddr[ADDR_W-1:2] == REG_BUCKET_COUNT);
	assign cfg_write = psel && penable && pwrite && pready && reg_sel;
	assign pready    = 1'b1;
	assign prdata    = reg_sel ? APB_DATA_W'(bucket_count_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bucket_count_q <= BUCKET_COUNT_RESET;
		end else if (cfg_write) begin
			bucket_count_q <= pwdata[BUCKET_W-1:0];
		end
	end

	// Modulus in use and key magnitude
	always_comb begin
		if (bucket_count_q == '0) begin
			modulus = BUCKET_W'(1);
		end else if (bucket_count_q > MOD_CAP) begin
			modulus = MOD_CAP;
		end else begin
			modulus = bucket_count_q;
		end
		key_bits  = in_data.key;
		magnitude = key_bits[KEY_W-1] ? (~key_bits + KEY_W'(1)) : key_bits;
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_HASH;
				end
			end
			ST_HASH: begin
				if (div_done) begin
					state_d = ST_SEARCH;
				end
			end
			ST_SEARCH: begin
				if (search_stat.done) begin
					state_d = ST_OUTPUT;
				end
			end
			ST_OUTPUT: begin
				if (!out_valid_q || !out_stall) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Sequencer outputs
	always_comb begin
		in_stall     = (state_q != ST_IDLE);
		div_start    = (state_q == ST_IDLE) && in_valid;
		search_start = (state_q == ST_HASH) && div_done;
		out_load     = (state_q == ST_OUTPUT) && (!out_valid_q || !out_stall);
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Request and result payload registers
	always_ff @(posedge clk) begin
		if (div_start) begin
			op_q  <= in_data.op;
			key_q <= in_data.key;
		end
		if (search_start) begin
			bucket_q <= div_rem;
		end
		if (out_load) begin
			out_data_q.present      <= search_stat.present;
			out_data_q.added        <= search_stat.added;
			out_data_q.bucket_full  <= search_stat.full;
			out_data_q.bucket_index <= bucket_q[2:0];
		end
	end

	ihs_mod_unit u_mod (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (magnitude),
		.divisor   (modulus),
		.done      (div_done),
		.remainder (div_rem)
	);

	assign search_req = '{op: op_q, key: key_q, bucket: div_rem};

	ihs_bucket_search #(
		.BUCKETS          (BUCKETS),
		.SLOTS_PER_BUCKET (SLOTS_PER_BUCKET)
	) u_search (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (search_start),
		.req    (search_req),
		.stat   (search_stat)
	);

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// Once a beat is taken the block stalls until that request is finished.
	a_stall_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second request accepted while busy");

	// A result appears only from the output state.
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == ST_OUTPUT))
		else $error("result raised outside output state");

	// The hash never divides by zero.
	a_modulus_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> modulus != '0 && modulus <= MOD_CAP)
		else $error("modulus out of range");

endmodule
